### hw/rtl/spas_pkg.sv
package spas_pkg;
  localparam int unsigned MaxTermsDefault = 64;
  localparam int unsigned ExpW  = 16;
  localparam int unsigned CoefW = 32;
  localparam int unsigned TermW = ExpW + CoefW;

  typedef enum logic [2:0] {
    FUNC_INS_FIRST  = 3'd0,
    FUNC_INS_SECOND = 3'd1,
    FUNC_ADD        = 3'd2,
    FUNC_SUB        = 3'd3,
    FUNC_READ       = 3'd4
  } func_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_SCAN,
    S_INS_SHIFT,
    S_INS_PUT,
    S_MRG_RD,
    S_MRG_STEP,
    S_CPY_RD,
    S_CPY_WR,
    S_RD_RD,
    S_RD_OUT,
    S_DONE
  } state_e;

  function automatic logic signed [CoefW-1:0] sat32(input logic signed [CoefW:0] v);
    logic signed [CoefW-1:0] r;
    if (v[CoefW] != v[CoefW-1]) begin
      r = v[CoefW] ? {1'b1, {(CoefW-1){1'b0}}} : {1'b0, {(CoefW-1){1'b1}}};
    end else begin
      r = v[CoefW-1:0];
    end
    return r;
  endfunction
endpackage

### hw/rtl/sparse_polynomial_add_sub_unit.sv
// Sparse polynomial add/subtract unit.
// Two term tables (first, second) are held sorted by ascending signed exponent.
// Requests are issued with start_i while busy_o is low; func_i picks the work:
// insert into first, insert into second, add or subtract second into first,
// or read first. Each request yields one or more results, each shown for one
// cycle with result_valid_o; last_o marks the final result of the request.
// Inserts, merges and empty reads give one status; other reads give every term.
// An insert scans the target table from the top, moving each entry whose
// exponent is not below the new one up a place, then writes the new term. A
// merge buffers the lower-exponent term or a nonzero sum of equal ones, then
// copies the buffer into first; a read streams first's terms. busy_o stays high
// through the cycle that shows the last result; the next request may be issued
// after it. Merges use a shared adder/comparator and one read port per table.
// Reset clears both term counts and the sequencer; table contents are not
// cleared, entries beyond the counts are never used. The receiver cannot
// stall, so results are driven straight from the output register.
module sparse_polynomial_add_sub_unit
  import spas_pkg::*;
#(
  parameter int unsigned MaxTerms = MaxTermsDefault
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  output logic                    busy_o,
  input  logic [2:0]              func_i,
  input  logic signed [ExpW-1:0]  exponent_i,
  input  logic signed [CoefW-1:0] coefficient_i,
  output logic                    result_valid_o,
  output logic signed [ExpW-1:0]  term_exponent_o,
  output logic signed [CoefW-1:0] term_coefficient_o,
  output logic                    last_o,
  output logic [1:0]              status_o
);
  localparam int unsigned AW = $clog2(MaxTerms);
  localparam int unsigned CW = $clog2(MaxTerms + 1);
  localparam logic [CW-1:0] MaxCnt = CW'(MaxTerms);

  state_e state_q, state_d;
  logic [CW-1:0] cnt1_q, cnt1_d, cnt2_q, cnt2_d;
  logic [CW-1:0] i_q, i_d, j_q, j_d, m_q, m_d;
  logic          sel2_q, sel2_d, sub_q, sub_d, ok_q, ok_d;
  logic signed [ExpW-1:0]  e_q, e_d;
  logic signed [CoefW-1:0] c_q, c_d;
  logic          accept;
  logic          rd_empty_q;

  // RAM ports
  logic          we1, we2, web;
  logic [AW-1:0] wa1, wa2, wab, ra1, ra2, rab;
  logic [TermW-1:0] wd1, wd2, wdb, rd1, rd2, rdb;

  spas_ram #(.Width(TermW), .Depth(MaxTerms)) u_first (
    .clk_i, .we_i(we1), .waddr_i(wa1), .wdata_i(wd1), .raddr_i(ra1), .rdata_o(rd1));
  spas_ram #(.Width(TermW), .Depth(MaxTerms)) u_second (
    .clk_i, .we_i(we2), .waddr_i(wa2), .wdata_i(wd2), .raddr_i(ra2), .rdata_o(rd2));
  spas_ram #(.Width(TermW), .Depth(MaxTerms)) u_buf (
    .clk_i, .we_i(web), .waddr_i(wab), .wdata_i(wdb), .raddr_i(rab), .rdata_o(rdb));

  // Output register
  logic                    rv_q, rv_d, last_q, last_d;
  logic [1:0]              st_q, st_d;
  logic signed [ExpW-1:0]  oe_q, oe_d;
  logic signed [CoefW-1:0] oc_q, oc_d;

  // Insert target view
  logic [TermW-1:0] trd;
  assign trd  = sel2_q ? rd2 : rd1;

  logic signed [ExpW-1:0]  ae, be;
  logic signed [CoefW-1:0] ac, bc;
  assign ae = rd1[TermW-1:CoefW];
  assign ac = rd1[CoefW-1:0];
  assign be = rd2[TermW-1:CoefW];
  assign bc = rd2[CoefW-1:0];

  // Take a request only when idle and no result is still on show
  assign accept = start_i && !busy_o;

  // Shared adder: a +/- b, with either operand gated to zero
  logic signed [CoefW:0] add_a, add_b, add_s;
  logic have_a, have_b;
  assign have_a = i_q < cnt1_q;
  assign have_b = j_q < cnt2_q;

  always_comb begin
    add_a = '0;
    add_b = '0;
    if (have_a && (!have_b || ae <= be)) begin
      add_a = {ac[CoefW-1], ac};
    end
    if (have_b && (!have_a || be <= ae)) begin
      add_b = {bc[CoefW-1], bc};
    end
    add_s = sub_q ? add_a - add_b : add_a + add_b;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt1_q  <= '0;
      cnt2_q  <= '0;
      rv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt1_q  <= cnt1_d;
      cnt2_q  <= cnt2_d;
      rv_q    <= rv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q <= i_d; j_q <= j_d; m_q <= m_d;
    sel2_q <= sel2_d; sub_q <= sub_d; ok_q <= ok_d;
    e_q <= e_d; c_q <= c_d;
    last_q <= last_d; st_q <= st_d; oe_q <= oe_d; oc_q <= oc_d;
  end

  // Note whether the accepted request is a read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) rd_empty_q <= 1'b0;
    else if (accept) rd_empty_q <= (func_i == FUNC_READ);
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (func_i)
            FUNC_INS_FIRST:  state_d = (cnt1_q >= MaxCnt) ? S_DONE :
                                       (cnt1_q == '0) ? S_INS_PUT : S_INS_SCAN;
            FUNC_INS_SECOND: state_d = (cnt2_q >= MaxCnt) ? S_DONE :
                                       (cnt2_q == '0) ? S_INS_PUT : S_INS_SCAN;
            FUNC_ADD, FUNC_SUB: state_d = S_MRG_RD;
            FUNC_READ:       state_d = (cnt1_q == '0) ? S_DONE : S_RD_RD;
            default:         state_d = S_IDLE;
          endcase
        end
      end
      // j_q walks down from the top: move entry j-1 up while its exponent >= e
      S_INS_SCAN:  state_d = S_INS_SHIFT;
      S_INS_SHIFT: begin
        if ($signed(trd[TermW-1:CoefW]) >= e_q) begin
          state_d = (j_q == CW'(1)) ? S_INS_PUT : S_INS_SCAN;
        end else begin
          state_d = S_INS_PUT;
        end
      end
      S_INS_PUT:  state_d = S_DONE;
      S_MRG_RD:   state_d = (!have_a && !have_b) ? S_CPY_RD : S_MRG_STEP;
      S_MRG_STEP: state_d = S_MRG_RD;
      S_CPY_RD:   state_d = (i_q >= m_q) ? S_DONE : S_CPY_WR;
      S_CPY_WR:   state_d = S_CPY_RD;
      S_RD_RD:    state_d = S_RD_OUT;
      S_RD_OUT:   state_d = (i_q + CW'(1) >= cnt1_q) ? S_IDLE : S_RD_RD;
      S_DONE:     state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    cnt1_d = cnt1_q; cnt2_d = cnt2_q;
    i_d = i_q; j_d = j_q; m_d = m_q;
    sel2_d = sel2_q; sub_d = sub_q; ok_d = ok_q;
    e_d = e_q; c_d = c_q;
    rv_d = 1'b0; last_d = 1'b1; st_d = ST_OK; oe_d = '0; oc_d = '0;
    we1 = 1'b0; we2 = 1'b0; web = 1'b0;
    wa1 = '0; wa2 = '0; wab = m_q[AW-1:0];
    wd1 = '0; wd2 = '0; wdb = '0;
    ra1 = i_q[AW-1:0]; ra2 = j_q[AW-1:0]; rab = i_q[AW-1:0];
    case (state_q)
      S_IDLE: begin
        e_d = exponent_i; c_d = coefficient_i;
        sel2_d = (func_i == FUNC_INS_SECOND);
        sub_d  = (func_i == FUNC_SUB);
        i_d = '0; m_d = '0; ok_d = 1'b1;
        j_d = (func_i == FUNC_INS_SECOND) ? cnt2_q : (func_i == FUNC_INS_FIRST) ? cnt1_q : '0;
        if (accept && ((func_i == FUNC_INS_FIRST && cnt1_q >= MaxCnt) ||
                       (func_i == FUNC_INS_SECOND && cnt2_q >= MaxCnt))) begin
          ok_d = 1'b0;
        end
      end
      S_INS_SCAN: begin
        ra1 = AW'(j_q - CW'(1));
        ra2 = AW'(j_q - CW'(1));
      end
      S_INS_SHIFT: begin
        if ($signed(trd[TermW-1:CoefW]) >= e_q) begin
          wa1 = j_q[AW-1:0]; wa2 = j_q[AW-1:0];
          wd1 = trd; wd2 = trd;
          we1 = !sel2_q; we2 = sel2_q;
          j_d = j_q - CW'(1);
        end
      end
      S_INS_PUT: begin
        wa1 = j_q[AW-1:0]; wa2 = j_q[AW-1:0];
        wd1 = {e_q, c_q}; wd2 = {e_q, c_q};
        we1 = !sel2_q; we2 = sel2_q;
        if (sel2_q) cnt2_d = cnt2_q + CW'(1);
        else        cnt1_d = cnt1_q + CW'(1);
      end
      S_MRG_RD: begin
        // Both tables walked: restart the index for the copy back
        if (!have_a && !have_b) i_d = '0;
      end
      S_MRG_STEP: begin
        // Drop a zero sum only when both sides paired
        if (!(have_a && have_b && ae == be && add_s == '0)) begin
          if (m_q >= MaxCnt) begin
            ok_d = 1'b0;
          end else begin
            web = 1'b1;
            wdb = {(have_a && (!have_b || ae <= be)) ? ae : be, sat32(add_s)};
            m_d = m_q + CW'(1);
          end
        end
        if (have_a && (!have_b || ae <= be)) i_d = i_q + CW'(1);
        if (have_b && (!have_a || be <= ae)) j_d = j_q + CW'(1);
      end
      S_CPY_RD: begin
        if (i_q >= m_q) cnt1_d = m_q;
      end
      S_CPY_WR: begin
        we1 = 1'b1; wa1 = i_q[AW-1:0]; wd1 = rdb;
        i_d = i_q + CW'(1);
      end
      S_RD_OUT: begin
        rv_d = 1'b1;
        oe_d = ae; oc_d = ac;
        last_d = (i_q + CW'(1) >= cnt1_q);
        i_d = i_q + CW'(1);
      end
      S_DONE: begin
        // A read only ends here when the table is empty
        rv_d = 1'b1;
        st_d = rd_empty_q ? ST_EMPTY : (ok_q ? ST_OK : ST_FULL);
      end
      default: ;
    endcase
  end

  assign busy_o             = (state_q != S_IDLE) || rv_q;
  assign result_valid_o     = rv_q;
  assign term_exponent_o    = oe_q;
  assign term_coefficient_o = oc_q;
  assign last_o             = last_q;
  assign status_o           = st_q;
endmodule

### hw/rtl/spas_ram.sv
module spas_ram #(
  parameter int unsigned Width = 48,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
